/* rtl/mmc_pkg.sv */
`default_nettype none

package mmc_pkg;

   // controller states
   localparam logic [2:0] ST_INITIAL = 3'd0;
   localparam logic [2:0] ST_AUTO    = 3'd1;
   localparam logic [2:0] ST_MANUAL  = 3'd2;
   localparam logic [2:0] ST_RESET   = 3'd3;
   localparam logic [2:0] ST_PANIC   = 3'd4;

   // remembered modes
   localparam logic [1:0] MODE_INITIAL = 2'd0;
   localparam logic [1:0] MODE_AUTO    = 2'd1;
   localparam logic [1:0] MODE_MANUAL  = 2'd2;
   localparam logic [1:0] MODE_RESET   = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_ES_MASK      = 3'd0;
   localparam logic [2:0] CSR_M10_MASK     = 3'd1;
   localparam logic [2:0] CSR_OPERATE_MASK = 3'd2;
   localparam logic [2:0] CSR_SWITCH_MASK  = 3'd3;
   localparam logic [2:0] CSR_AUTO_CODE    = 3'd4;
   localparam logic [2:0] CSR_MANUAL_CODE  = 3'd5;
   localparam logic [2:0] CSR_RESET_CODE   = 3'd6;

   localparam int unsigned WORD_W     = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned RSP_DATA_W = 32;

   typedef struct packed {
      logic [15:0] es_mask;
      logic [15:0] m10_mask;
      logic [15:0] operate_mask;
      logic [15:0] switch_mask;
      logic [15:0] auto_code;
      logic [15:0] manual_code;
      logic [15:0] reset_code;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  ctrl_state;
      logic [1:0]  mode;
      logic [15:0] prev_word;
      logic        seen_first;
      logic        edge_parity;
      logic        m10_flag;
   } ctx_type;

   typedef struct packed {
      logic [2:0]  ctrl_state;
      logic [1:0]  mode_now;
      logic        transit_cmd;
      logic [15:0] transit_word;
      logic        cylinder_reset_cmd;
      logic        move_cmd;
      logic        m10_seen;
   } result_type;

endpackage

`default_nettype wire

/* rtl/mmc_csr.sv */
`default_nettype none

module mmc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [mmc_pkg::CSR_IDX_W-1:0]     wr_index,
   input  wire logic [mmc_pkg::WORD_W-1:0]        wr_data,
   output mmc_pkg::cfg_type                       cfg
);

   mmc_pkg::cfg_type cfg_ff;
   mmc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            mmc_pkg::CSR_ES_MASK:      cfg_in.es_mask      = wr_data;
            mmc_pkg::CSR_M10_MASK:     cfg_in.m10_mask     = wr_data;
            mmc_pkg::CSR_OPERATE_MASK: cfg_in.operate_mask = wr_data;
            mmc_pkg::CSR_SWITCH_MASK:  cfg_in.switch_mask  = wr_data;
            mmc_pkg::CSR_AUTO_CODE:    cfg_in.auto_code    = wr_data;
            mmc_pkg::CSR_MANUAL_CODE:  cfg_in.manual_code  = wr_data;
            mmc_pkg::CSR_RESET_CODE:   cfg_in.reset_code   = wr_data;
            default: ; // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/mmc_step.sv */
`default_nettype none

module mmc_step (
   input  wire mmc_pkg::cfg_type              cfg,
   input  wire mmc_pkg::ctx_type              ctx,
   input  wire logic [mmc_pkg::WORD_W-1:0]    word,
   output mmc_pkg::ctx_type                   ctx_next,
   output mmc_pkg::result_type                result
);

   logic [15:0] last;
   logic [15:0] sw;
   logic        es_fall;
   logic        es_rise;
   logic        m10_rise;
   logic        op_rise;
   logic        sw_change;
   logic [2:0]  st;
   logic [1:0]  mode;
   logic        clr;
   logic        parity;
   logic        transit;
   logic        cyl_reset;

   always_comb begin
      last      = ctx.seen_first ? ctx.prev_word : (cfg.es_mask | cfg.switch_mask);
      sw        = word & cfg.switch_mask;
      es_fall   = |(last & ~word & cfg.es_mask);
      es_rise   = |(~last & word & cfg.es_mask);
      m10_rise  = |(~last & word & cfg.m10_mask);
      op_rise   = |(~last & word & cfg.operate_mask);
      sw_change = |((last ^ word) & cfg.switch_mask);

      st   = ctx.ctrl_state;
      mode = ctx.mode;
      clr  = 1'b0;

      if (es_fall) begin
         st  = mmc_pkg::ST_PANIC;
         clr = 1'b1;
      end else if (es_rise && ctx.ctrl_state == mmc_pkg::ST_PANIC) begin
         st  = mmc_pkg::ST_INITIAL;
         clr = 1'b1;
      end

      // switch change overrides even panic; first differing match wins
      if (sw_change) begin
         if (sw == cfg.auto_code && mode != mmc_pkg::MODE_AUTO) begin
            mode = mmc_pkg::MODE_AUTO;
            st   = mmc_pkg::ST_AUTO;
            clr  = 1'b1;
         end else if (sw == cfg.manual_code && mode != mmc_pkg::MODE_MANUAL) begin
            mode = mmc_pkg::MODE_MANUAL;
            st   = mmc_pkg::ST_MANUAL;
            clr  = 1'b1;
         end else if (sw == cfg.reset_code && mode != mmc_pkg::MODE_RESET) begin
            mode = mmc_pkg::MODE_RESET;
            st   = mmc_pkg::ST_RESET;
            clr  = 1'b1;
         end
      end

      parity    = clr ? 1'b0 : ctx.edge_parity;
      transit   = 1'b0;
      cyl_reset = 1'b0;

      case (st)
         mmc_pkg::ST_AUTO: begin
            parity  = parity ^ op_rise;
            transit = parity;
         end
         mmc_pkg::ST_MANUAL: begin
            parity  = parity ^ op_rise;
            transit = op_rise;
         end
         mmc_pkg::ST_RESET: begin
            parity    = parity ^ op_rise;
            cyl_reset = op_rise;
         end
         mmc_pkg::ST_INITIAL: begin
            cyl_reset = 1'b1;
         end
         default: ; // panic: no commands
      endcase

      ctx_next.ctrl_state  = st;
      ctx_next.mode        = mode;
      ctx_next.prev_word   = word;
      ctx_next.seen_first  = 1'b1;
      ctx_next.edge_parity = parity;
      ctx_next.m10_flag    = ctx.m10_flag | m10_rise;

      result.ctrl_state         = st;
      result.mode_now           = mode;
      result.transit_cmd        = transit;
      result.transit_word       = transit ? word : '0;
      result.cylinder_reset_cmd = cyl_reset;
      result.move_cmd           = 1'b1;
      result.m10_seen           = ctx_next.m10_flag;
   end

endmodule

`default_nettype wire

/* rtl/machine_mode_controller_core.sv */
// An input transfer reaches its result through the input register and then the result register.
// Throughput: one input word per cycle while results are taken; the step logic runs once per word.
// A full result register that is not taken stalls the step; the input register then holds.
// Reset (synchronous, active high) clears all masks and codes, enters Initial mode and state,
// clears the first-word, parity and M10 flags and empties both registers.
`default_nettype none

module machine_mode_controller_core (
   input  wire logic                                clock,
   input  wire logic                                reset,

   // input words
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [mmc_pkg::WORD_W-1:0]          req_tdata,   // [15:0] input_word

   // results
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [2:0] ctrl_state, [4:3] mode_now, [5] transit_cmd, [21:6] transit_word,
   // [22] cylinder_reset_cmd, [23] move_cmd, [24] m10_seen, [31:25] zero
   output logic [mmc_pkg::RSP_DATA_W-1:0]           rsp_tdata,

   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mmc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mmc_pkg::WORD_W-1:0]          csr_wdata
);

   mmc_pkg::cfg_type    cfg;
   mmc_pkg::ctx_type    ctx_ff;
   mmc_pkg::ctx_type    ctx_in;
   mmc_pkg::result_type step_result;
   mmc_pkg::result_type rsp_data_ff;

   logic                        in_valid_ff;
   logic [mmc_pkg::WORD_W-1:0]  in_word_ff;
   logic                        rsp_valid_ff;
   logic                        step_go;
   logic                        req_xfer;

   // Register file: writes always taken, only while idle by contract.
   assign csr_ready = 1'b1;

   mmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // One tick of the controller, combinational from the input register.
   mmc_step u_step (
      .cfg      (cfg),
      .ctx      (ctx_ff),
      .word     (in_word_ff),
      .ctx_next (ctx_in),
      .result   (step_result)
   );

   // Step fires when a word is held and the result slot is free or draining.
   assign step_go    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_go;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_xfer || (in_valid_ff && !step_go);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_word_ff <= req_tdata;
      end
   end

   // controller state advances once per stepped word
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.ctrl_state  <= mmc_pkg::ST_INITIAL;
         ctx_ff.mode        <= mmc_pkg::MODE_INITIAL;
         ctx_ff.prev_word   <= '0;
         ctx_ff.seen_first  <= 1'b0;
         ctx_ff.edge_parity <= 1'b0;
         ctx_ff.m10_flag    <= 1'b0;
      end else if (step_go) begin
         ctx_ff <= ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= step_go || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0,
                        rsp_data_ff.m10_seen,
                        rsp_data_ff.move_cmd,
                        rsp_data_ff.cylinder_reset_cmd,
                        rsp_data_ff.transit_word,
                        rsp_data_ff.transit_cmd,
                        rsp_data_ff.mode_now,
                        rsp_data_ff.ctrl_state};

   // Transit and cylinder reset come from disjoint states.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.transit_cmd && rsp_data_ff.cylinder_reset_cmd))
      else $error("transit and cylinder reset commanded together");

   // Word only passes with a transit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.transit_cmd) |-> (rsp_data_ff.transit_word == '0))
      else $error("transit word without transit command");

   // Panic commands nothing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.ctrl_state == mmc_pkg::ST_PANIC)
         |-> !(rsp_data_ff.transit_cmd || rsp_data_ff.cylinder_reset_cmd))
      else $error("command issued in panic");

   // M10 flag is sticky once a step has set it.
   assert property (@(posedge clock) disable iff (reset)
      (step_go && ctx_ff.m10_flag) |=> ctx_ff.m10_flag)
      else $error("m10 flag cleared");

   // Stepped state stays a defined controller state.
   assert property (@(posedge clock) disable iff (reset)
      ctx_ff.ctrl_state <= mmc_pkg::ST_PANIC)
      else $error("controller state out of range");

endmodule

`default_nettype wire

/* tb/mode_controller_checker.sv */
`timescale 1ns / 1ps

module mode_controller_checker
   import mmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [WORD_W-1:0]     req_tdata,

   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,

   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [WORD_W-1:0]     csr_wdata,

   output int                         mismatch_count,
   output int                         results_seen,
   output int                         results_outstanding
);

   // own copy of the registers and of the controller state
   cfg_type     regs;
   logic [2:0]  state_q;
   logic [1:0]  mode_q;
   logic [15:0] last_word;
   logic        have_word;
   logic        parity_q;
   logic        m10_sticky;

   result_type  step_results_due[$];

   function automatic void enter_state(input logic [2:0] st);
      state_q  = st;
      parity_q = 1'b0;
   endfunction

   function automatic result_type advance_controller(input logic [15:0] now);
      logic [15:0] last;
      logic [15:0] sw;
      logic        rise;
      result_type  r;
      // before the first word, the idle level is stop released, switch bits high
      last = have_word ? last_word : (regs.es_mask | regs.switch_mask);
      sw   = now & regs.switch_mask;
      last_word = now;
      have_word = 1'b1;

      if ((last & ~now & regs.es_mask) != '0)
         enter_state(ST_PANIC);
      else if ((~last & now & regs.es_mask) != '0 && state_q == ST_PANIC)
         enter_state(ST_INITIAL);

      if ((~last & now & regs.m10_mask) != '0)
         m10_sticky = 1'b1;

      // first code in auto, manual, reset order that moves the mode wins,
      // panic or not
      if (((last ^ now) & regs.switch_mask) != '0) begin
         if (sw == regs.auto_code && mode_q != MODE_AUTO) begin
            mode_q = MODE_AUTO;
            enter_state(ST_AUTO);
         end else if (sw == regs.manual_code && mode_q != MODE_MANUAL) begin
            mode_q = MODE_MANUAL;
            enter_state(ST_MANUAL);
         end else if (sw == regs.reset_code && mode_q != MODE_RESET) begin
            mode_q = MODE_RESET;
            enter_state(ST_RESET);
         end
      end

      rise = ((~last & now & regs.operate_mask) != '0);
      r = '0;
      case (state_q)
         ST_AUTO: begin
            if (rise)
               parity_q = ~parity_q;
            if (parity_q) begin
               r.transit_cmd  = 1'b1;
               r.transit_word = now;
            end
         end
         ST_MANUAL: begin
            if (rise) begin
               parity_q       = ~parity_q;
               r.transit_cmd  = 1'b1;
               r.transit_word = now;
            end
         end
         ST_RESET: begin
            if (rise) begin
               parity_q             = ~parity_q;
               r.cylinder_reset_cmd = 1'b1;
            end
         end
         ST_INITIAL: r.cylinder_reset_cmd = 1'b1;
         default: ;
      endcase

      r.ctrl_state = state_q;
      r.mode_now   = mode_q;
      r.move_cmd   = 1'b1;
      r.m10_seen   = m10_sticky;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         regs       = '0;
         state_q    = ST_INITIAL;
         mode_q     = MODE_INITIAL;
         last_word  = '0;
         have_word  = 1'b0;
         parity_q   = 1'b0;
         m10_sticky = 1'b0;
         step_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ES_MASK:      regs.es_mask      = csr_wdata;
               CSR_M10_MASK:     regs.m10_mask     = csr_wdata;
               CSR_OPERATE_MASK: regs.operate_mask = csr_wdata;
               CSR_SWITCH_MASK:  regs.switch_mask  = csr_wdata;
               CSR_AUTO_CODE:    regs.auto_code    = csr_wdata;
               CSR_MANUAL_CODE:  regs.manual_code  = csr_wdata;
               CSR_RESET_CODE:   regs.reset_code   = csr_wdata;
               default: ;
            endcase
         end

         if (req_tvalid && req_tready)
            step_results_due.push_back(advance_controller(req_tdata));

         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (step_results_due.size() == 0) begin
               report_mismatch($sformatf("result %08h with nothing expected", rsp_tdata));
            end else begin
               want = step_results_due.pop_front();
               compare_field("ctrl_state", rsp_tdata[2:0], want.ctrl_state);
               compare_field("mode_now", rsp_tdata[4:3], want.mode_now);
               compare_field("transit_cmd", rsp_tdata[5], want.transit_cmd);
               compare_field("transit_word", rsp_tdata[21:6], want.transit_word);
               compare_field("cylinder_reset_cmd", rsp_tdata[22], want.cylinder_reset_cmd);
               compare_field("move_cmd", rsp_tdata[23], want.move_cmd);
               compare_field("m10_seen", rsp_tdata[24], want.m10_seen);
               compare_field("pad bits", rsp_tdata[31:25], '0);
            end
         end
      end
      results_outstanding <= step_results_due.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import mmc_pkg::*;

   // index with no register behind it; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam int RANDOM_PHASES  = 10;
   localparam int WORDS_PER_PHASE = 93;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata = '0;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [WORD_W-1:0]     csr_wdata = '0;

   // gaps on the word side and stalls on the result side only while set
   bit                    idling = 1'b0;
   int unsigned           hold_left = 0;

   int                    mismatch_count;
   int                    results_seen;
   int                    results_outstanding;
   int                    words_sent = 0;
   int                    settings_loaded = 0;
   logic [15:0]           cur_word = '0;

   machine_mode_controller_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mode_controller_checker step_check (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .results_seen        (results_seen),
      .results_outstanding (results_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: ready most of the time, with random stall bursts while idling is set
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         hold_left  <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic cfg_type make_cfg(input logic [15:0] es, input logic [15:0] m10,
                                        input logic [15:0] op, input logic [15:0] sw,
                                        input logic [15:0] au, input logic [15:0] ma,
                                        input logic [15:0] rs);
      cfg_type c;
      c.es_mask      = es;
      c.m10_mask     = m10;
      c.operate_mask = op;
      c.switch_mask  = sw;
      c.auto_code    = au;
      c.manual_code  = ma;
      c.reset_code   = rs;
      return c;
   endfunction

   // a mask of up to n scattered bits (may be zero, bits may repeat)
   function automatic logic [15:0] pick_bits(input int unsigned n);
      logic [15:0] m;
      m = '0;
      repeat (n) m[$urandom_range(0, 15)] = 1'b1;
      return m;
   endfunction

   // Masks mostly narrow so edges are frequent; codes mostly inside the
   // switch mask so mode changes happen. Occasionally a wide stop mask,
   // a code outside the switch bits, or two equal codes.
   function automatic cfg_type random_settings();
      cfg_type c;
      c.es_mask      = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                    : pick_bits($urandom_range(0, 2));
      c.m10_mask     = pick_bits($urandom_range(0, 2));
      c.operate_mask = pick_bits($urandom_range(0, 2));
      c.switch_mask  = pick_bits($urandom_range(1, 3));
      c.auto_code    = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                    : 16'($urandom_range(0, 16'hFFFF))
                                                      & c.switch_mask;
      c.manual_code  = 16'($urandom_range(0, 16'hFFFF)) & c.switch_mask;
      c.reset_code   = ($urandom_range(0, 5) == 0) ? c.manual_code
                                                    : 16'($urandom_range(0, 16'hFFFF))
                                                      & c.switch_mask;
      return c;
   endfunction

   // Next port word: mostly a single toggle on a watched bit, sometimes a
   // jump of the selector straight to a mode code, a stray bit flip, or noise.
   function automatic logic [15:0] next_word(input logic [15:0] w, input cfg_type c);
      logic [15:0] live;
      logic [15:0] code;
      int unsigned pos;
      int unsigned pick;
      live = c.es_mask | c.m10_mask | c.operate_mask | c.switch_mask;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return 16'($urandom_range(0, 16'hFFFF));
      if (pick < 4 || live == '0)
         return w ^ (16'h0001 << $urandom_range(0, 15));
      if (pick < 7) begin
         case ($urandom_range(0, 2))
            0: code = c.auto_code;
            1: code = c.manual_code;
            default: code = c.reset_code;
         endcase
         return (w & ~c.switch_mask) | (code & c.switch_mask);
      end
      do
         pos = $urandom_range(0, 15);
      while (!live[pos]);
      return w ^ (16'h0001 << pos);
   endfunction

   // leaves csr_valid high so writes can run back to back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_ES_MASK, c.es_mask);
      write_reg(CSR_M10_MASK, c.m10_mask);
      write_reg(CSR_OPERATE_MASK, c.operate_mask);
      write_reg(CSR_SWITCH_MASK, c.switch_mask);
      write_reg(CSR_AUTO_CODE, c.auto_code);
      write_reg(CSR_MANUAL_CODE, c.manual_code);
      write_reg(CSR_RESET_CODE, c.reset_code);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // one word transfer, with an optional gap ahead of it
   task automatic send_word(input logic [15:0] w);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      cur_word = w;
      words_sent++;
   endtask

   // stop sending and hold off until every predicted result has been taken,
   // with extra margin to cover the two-stage pipeline
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      cfg_type c;
      repeat (11) @(posedge clock);
      reset  <= 1'b0;
      idling <= 1'b1;

      // Directed part. Stop on bit 0 (active low), M10 on bit 1, operate
      // on bit 2, selector on bits 5:4 with 01 auto, 10 manual, 11 reset.
      program_regs(make_cfg(16'h0001, 16'h0002, 16'h0004, 16'h0030,
                            16'h0010, 16'h0020, 16'h0030));
      send_word(16'h0001);  // first word: selector drops from idle level, no code
      send_word(16'h0011);  // selector to auto
      send_word(16'h0015);  // operate rise, parity odd -> transit
      send_word(16'h0011);  // operate release, parity still odd -> transit
      send_word(16'h0015);  // second rise, parity even -> quiet
      send_word(16'h0017);  // M10 rise sets the sticky flag
      send_word(16'h0010);  // stop pressed -> panic
      send_word(16'h0014);  // operate rise in panic does nothing
      send_word(16'h0015);  // stop released in panic -> initial
      send_word(16'h0021);  // selector to manual
      send_word(16'h0025);  // operate rise in manual -> transit
      send_word(16'h0020);  // stop pressed again -> panic
      send_word(16'h0030);  // selector to reset while in panic
      send_word(16'h0034);  // operate rise in reset -> cylinder reset
      send_word(16'hFFFF);  // every bit high
      send_word(16'h0000);  // every bit low, stop pressed
      drain_results();

      // all three codes equal: each selector change picks the first mode, in auto,
      // manual, reset order, that differs from the remembered one; spare index written too
      write_reg(CSR_SPARE, 16'hFFFF);
      program_regs(make_cfg(16'h0001, 16'h0002, 16'h0004, 16'h0030,
                            16'h0010, 16'h0010, 16'h0010));
      send_word(16'h0011);
      send_word(16'h0001);
      send_word(16'h0011);
      send_word(16'h0001);
      send_word(16'h0011);
      drain_results();

      // zero masks: no edges anywhere
      program_regs(make_cfg(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000));
      send_word(16'hA5A5);
      send_word(16'h5A5A);
      drain_results();

      // full masks, codes at both extremes
      program_regs(make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'h0000, 16'h8000));
      send_word(16'hFFFF);
      send_word(16'h0000);
      drain_results();

      // Random part: a fresh setting per phase. Some phases run without
      // any gaps or stalls, the last one always does.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idling <= (phase % 4 != 3) && (phase != RANDOM_PHASES - 1);
         c = random_settings();
         program_regs(c);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_word(next_word(cur_word, c));
            // mid-phase pause until the result side is empty
            if (n == 46 && phase % 3 == 1)
               drain_results();
         end
         drain_results();
      end

      $display("Covered %0d port words under %0d register settings, %0d results checked.",
               words_sent, settings_loaded, results_seen);
      $display("Included first-word idle level, panic entry/exit, all modes, equal codes, ",
               "zero and full masks.");
      if (mismatch_count == 0) begin
         $display("machine_mode_controller_core verification clean");
      end else begin
         $display("machine_mode_controller_core verification failed");
      end
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("machine_mode_controller_core verification failed");
      $finish;
   end

endmodule

/* machine_mode_controller_core.f */
rtl/mmc_pkg.sv
rtl/mmc_csr.sv
rtl/mmc_step.sv
rtl/machine_mode_controller_core.sv
tb/mode_controller_checker.sv
tb/testbench.sv
